FILE: rtl/mhl_pkg.sv
package mhl_pkg;

    localparam int WORD_W = 64;
    localparam int HALF_W = 32;
    localparam int KIND_W = 4;
    localparam int CNT_W  = $clog2(WORD_W);

    localparam logic [KIND_W-1:0] KIND_MULT   = 4'd0;
    localparam logic [KIND_W-1:0] KIND_MULTU  = 4'd1;
    localparam logic [KIND_W-1:0] KIND_DMULT  = 4'd2;
    localparam logic [KIND_W-1:0] KIND_DMULTU = 4'd3;
    localparam logic [KIND_W-1:0] KIND_DIV    = 4'd4;
    localparam logic [KIND_W-1:0] KIND_DIVU   = 4'd5;
    localparam logic [KIND_W-1:0] KIND_DDIV   = 4'd6;
    localparam logic [KIND_W-1:0] KIND_DDIVU  = 4'd7;
    localparam logic [KIND_W-1:0] KIND_MFHI   = 4'd8;
    localparam logic [KIND_W-1:0] KIND_MFLO   = 4'd9;
    localparam logic [KIND_W-1:0] KIND_MTHI   = 4'd10;
    localparam logic [KIND_W-1:0] KIND_MTLO   = 4'd11;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [WORD_W-1:0] operand_a;
        logic [WORD_W-1:0] operand_b;
    } cmd_t;

    typedef struct packed {
        logic [WORD_W-1:0] hi_value;
        logic [WORD_W-1:0] lo_value;
        logic [WORD_W-1:0] read_value;
    } res_t;

    // top to core
    typedef struct packed {
        logic              start;
        logic              take;
        logic [KIND_W-1:0] kind;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
    } core_ctl_t;

    // core to top
    typedef struct packed {
        logic              idle;
        logic              done;
        logic [WORD_W-1:0] hi;
        logic [WORD_W-1:0] lo;
    } core_sts_t;

    function automatic logic [WORD_W-1:0] sext32(input logic [HALF_W-1:0] v);
        return {{(WORD_W-HALF_W){v[HALF_W-1]}}, v};
    endfunction

endpackage

FILE: rtl/mhl_addsub.sv
module mhl_addsub
    import mhl_pkg::*;
(
    input  logic [WORD_W:0]   x,
    input  logic [WORD_W:0]   y,
    input  logic              cin,
    output logic [WORD_W+1:0] sum
);

    assign sum = {1'b0, x} + {1'b0, y} + {{(WORD_W+1){1'b0}}, cin};

endmodule

FILE: rtl/mhl_core.sv
module mhl_core
    import mhl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  core_ctl_t ctl,
    output core_sts_t sts
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_PRE_A  = 3'd1;
    localparam logic [2:0] ST_PRE_B  = 3'd2;
    localparam logic [2:0] ST_LOOP   = 3'd3;
    localparam logic [2:0] ST_POST_A = 3'd4;
    localparam logic [2:0] ST_POST_B = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_W - 1);

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              div_reg, div_next;
    logic              w_reg, w_next;
    logic              na_reg, na_next;
    logic              nb_reg, nb_next;
    logic [WORD_W-1:0] acc_reg, acc_next;
    logic [WORD_W-1:0] low_reg, low_next;
    logic [WORD_W-1:0] opd_reg, opd_next;
    logic [WORD_W-1:0] sav_reg, sav_next;

    logic [WORD_W:0]   add_x, add_y;
    logic              add_cin;
    logic [WORD_W+1:0] add_sum;

    logic              k_w, k_signed, k_div;
    logic [WORD_W-1:0] ext_a, ext_b;
    logic              neg_q;

    // decode of the arithmetic kind
    always_comb
    begin
        k_w      = 1'b0;
        k_signed = 1'b0;
        k_div    = 1'b0;
        case (ctl.kind)
            KIND_MULT:   begin k_w = 1'b1; k_signed = 1'b1; end
            KIND_MULTU:  begin k_w = 1'b1; end
            KIND_DMULT:  begin k_signed = 1'b1; end
            KIND_DMULTU: begin end
            KIND_DIV:    begin k_w = 1'b1; k_signed = 1'b1; k_div = 1'b1; end
            KIND_DIVU:   begin k_w = 1'b1; k_div = 1'b1; end
            KIND_DDIV:   begin k_signed = 1'b1; k_div = 1'b1; end
            KIND_DDIVU:  begin k_div = 1'b1; end
            default:     begin end
        endcase
        if (k_w)
        begin
            ext_a = k_signed ? sext32(ctl.a[HALF_W-1:0])
                             : {{(WORD_W-HALF_W){1'b0}}, ctl.a[HALF_W-1:0]};
            ext_b = k_signed ? sext32(ctl.b[HALF_W-1:0])
                             : {{(WORD_W-HALF_W){1'b0}}, ctl.b[HALF_W-1:0]};
        end
        else
        begin
            ext_a = ctl.a;
            ext_b = ctl.b;
        end
    end

    assign neg_q = na_reg ^ nb_reg;

    // operand selection for the shared adder
    always_comb
    begin
        add_x   = '0;
        add_y   = '0;
        add_cin = 1'b0;
        case (state_reg)
            ST_PRE_A:
            begin
                add_cin = div_reg & na_reg;
                add_y   = add_cin ? ~{1'b0, low_reg} : {1'b0, low_reg};
            end
            ST_PRE_B:
            begin
                add_cin = div_reg & nb_reg;
                add_y   = add_cin ? ~{1'b0, opd_reg} : {1'b0, opd_reg};
            end
            ST_LOOP:
            begin
                if (div_reg)
                begin
                    add_x   = {acc_reg, low_reg[WORD_W-1]};
                    add_y   = ~{1'b0, opd_reg};
                    add_cin = 1'b1;
                end
                else
                begin
                    add_x = {1'b0, acc_reg};
                    add_y = low_reg[0] ? {1'b0, opd_reg} : '0;
                end
            end
            ST_POST_A:
            begin
                if (div_reg)
                begin
                    add_cin = neg_q;
                    add_y   = neg_q ? ~{1'b0, low_reg} : {1'b0, low_reg};
                end
                else
                begin
                    add_x   = {1'b0, acc_reg};
                    add_cin = na_reg;
                    add_y   = na_reg ? ~{1'b0, opd_reg} : '0;
                end
            end
            ST_POST_B:
            begin
                if (div_reg)
                begin
                    add_cin = na_reg;
                    add_y   = na_reg ? ~{1'b0, acc_reg} : {1'b0, acc_reg};
                end
                else
                begin
                    add_x   = {1'b0, acc_reg};
                    add_cin = nb_reg;
                    add_y   = nb_reg ? ~{1'b0, sav_reg} : '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    mhl_addsub u_addsub (
        .x   (add_x),
        .y   (add_y),
        .cin (add_cin),
        .sum (add_sum)
    );

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        div_next   = div_reg;
        w_next     = w_reg;
        na_next    = na_reg;
        nb_next    = nb_reg;
        acc_next   = acc_reg;
        low_next   = low_reg;
        opd_next   = opd_reg;
        sav_next   = sav_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (ctl.start)
                begin
                    state_next = ST_PRE_A;
                    cnt_next   = '0;
                    div_next   = k_div;
                    w_next     = k_w;
                    acc_next   = '0;
                    low_next   = ext_a;
                    opd_next   = ext_b;
                    sav_next   = ext_a;
                    if (k_div)
                    begin
                        na_next = k_signed & ext_a[WORD_W-1];
                        nb_next = k_signed & ext_b[WORD_W-1];
                    end
                    else
                    begin
                        na_next = k_signed & ~k_w & ext_a[WORD_W-1];
                        nb_next = k_signed & ~k_w & ext_b[WORD_W-1];
                    end
                end
            end
            ST_PRE_A:
            begin
                low_next   = add_sum[WORD_W-1:0];
                state_next = ST_PRE_B;
            end
            ST_PRE_B:
            begin
                opd_next   = add_sum[WORD_W-1:0];
                state_next = ST_LOOP;
            end
            ST_LOOP:
            begin
                if (div_reg)
                begin
                    acc_next = add_sum[WORD_W+1] ? add_sum[WORD_W-1:0]
                                                 : add_x[WORD_W-1:0];
                    low_next = {low_reg[WORD_W-2:0], add_sum[WORD_W+1]};
                end
                else
                begin
                    acc_next = add_sum[WORD_W:1];
                    low_next = {add_sum[0], low_reg[WORD_W-1:1]};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_POST_A;
                end
            end
            ST_POST_A:
            begin
                if (div_reg)
                begin
                    low_next = add_sum[WORD_W-1:0];
                end
                else
                begin
                    acc_next = add_sum[WORD_W-1:0];
                end
                state_next = ST_POST_B;
            end
            ST_POST_B:
            begin
                acc_next   = add_sum[WORD_W-1:0];
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (ctl.take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
        w_reg   <= w_next;
        na_reg  <= na_next;
        nb_reg  <= nb_next;
        acc_reg <= acc_next;
        low_reg <= low_next;
        opd_reg <= opd_next;
        sav_reg <= sav_next;
    end

    always_comb
    begin
        sts.idle = (state_reg == ST_IDLE);
        sts.done = (state_reg == ST_DONE);
        if (!w_reg)
        begin
            sts.hi = acc_reg;
        end
        else if (div_reg)
        begin
            sts.hi = sext32(acc_reg[HALF_W-1:0]);
        end
        else
        begin
            sts.hi = sext32(low_reg[WORD_W-1:HALF_W]);
        end
        sts.lo = w_reg ? sext32(low_reg[HALF_W-1:0]) : low_reg;
    end

endmodule

FILE: rtl/mips64_hi_lo_multiply_divide_top.sv
// multiply/divide unit with the hi and lo registers of a 64-bit mips core
// cmd channel (cmd_valid/cmd_ready/cmd) takes one operation per transaction:
//   kind, operand_a and operand_b; res channel (res_valid/res_ready/res)
//   returns hi_value, lo_value and read_value for every operation
// multiplies and divides run on one shared 65-bit adder: operand sign fix (pre_a,
//   pre_b), one shift-add or shift-subtract step per operand bit in the loop, and
//   result fix (post_a, post_b); the result is registered once the output slot is
//   free, and the next command is accepted only after that
// mfhi, mflo, mthi, mtlo and unused kinds answer in the cycle after acceptance,
//   one transaction per cycle while res is drained
// hi and lo change when the result of the operation is registered
// reset clears hi, lo, res_valid and the core state and counter; no result is pending after reset
// when res_ready is low the result holds in the output register, a finished
//   multiply or divide holds in the unit, and cmd_ready stays low
module mips64_hi_lo_multiply_divide_top
    import mhl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_ready,
    input  cmd_t cmd,
    output logic res_valid,
    input  logic res_ready,
    output res_t res
);

    logic [WORD_W-1:0] hi_reg, hi_next;
    logic [WORD_W-1:0] lo_reg, lo_next;
    logic              res_valid_reg, res_valid_next;
    res_t              res_reg, res_next;

    core_ctl_t         ctl;
    core_sts_t         sts;

    logic              slot_free;
    logic              accept;
    logic              is_arith;

    assign slot_free = ~res_valid_reg | res_ready;
    assign cmd_ready = sts.idle & slot_free;
    assign accept    = cmd_valid & cmd_ready;
    assign is_arith  = ~cmd.kind[KIND_W-1];

    assign ctl.start = accept & is_arith;
    assign ctl.take  = sts.done & slot_free;
    assign ctl.kind  = cmd.kind;
    assign ctl.a     = cmd.operand_a;
    assign ctl.b     = cmd.operand_b;

    mhl_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .sts   (sts)
    );

    always_comb
    begin
        hi_next        = hi_reg;
        lo_next        = lo_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        if (ctl.take)
        begin
            hi_next             = sts.hi;
            lo_next             = sts.lo;
            res_next.hi_value   = sts.hi;
            res_next.lo_value   = sts.lo;
            res_next.read_value = '0;
            res_valid_next      = 1'b1;
        end
        else if (accept && !is_arith)
        begin
            res_next.read_value = '0;
            case (cmd.kind)
                KIND_MFHI: res_next.read_value = hi_reg;
                KIND_MFLO: res_next.read_value = lo_reg;
                KIND_MTHI: hi_next = cmd.operand_a;
                KIND_MTLO: lo_next = cmd.operand_a;
                default:   begin end
            endcase
            res_next.hi_value = hi_next;
            res_next.lo_value = lo_next;
            res_valid_next    = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hi_reg        <= '0;
            lo_reg        <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            hi_reg        <= hi_next;
            lo_reg        <= lo_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

FILE: tb/sv/tb_mips64_hi_lo_multiply_divide_top.sv
module tb_mips64_hi_lo_multiply_divide_top;
    import mhl_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 4'd12;
    localparam logic [KIND_W-1:0] KIND_LAST   = {KIND_W{1'b1}};
    localparam logic [WORD_W-1:0] ALL_ONES    = {WORD_W{1'b1}};
    localparam logic [WORD_W-1:0] MIN64       = 64'h8000_0000_0000_0000;
    localparam logic [WORD_W-1:0] MAX64       = 64'h7fff_ffff_ffff_ffff;
    localparam int                TAIL_CYCLES = 150;
    localparam int                PRINT_CAP   = 100;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_ready;
    cmd_t cmd = '0;
    logic res_valid;
    logic res_ready = 1'b0;
    res_t res;

    cmd_t cmd_queue[$];
    res_t awaited_res[$];
    res_t front_res;
    logic [WORD_W-1:0] model_hi = '0;
    logic [WORD_W-1:0] model_lo = '0;
    int send_idle_pct = 0;
    int res_stall_pct = 0;
    int mismatch_count = 0;

    mips64_hi_lo_multiply_divide_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    function automatic logic [WORD_W-1:0] widen_word(input logic [HALF_W-1:0] w);
        return {{(WORD_W-HALF_W){w[HALF_W-1]}}, w};
    endfunction

    // quotient truncates toward zero, remainder follows the dividend
    function automatic void signed_divide(input logic [WORD_W-1:0] n, input logic [WORD_W-1:0] d,
                                          output logic [WORD_W-1:0] q,
                                          output logic [WORD_W-1:0] r);
        logic [WORD_W-1:0] un;
        logic [WORD_W-1:0] ud;
        logic [WORD_W-1:0] uq;
        logic [WORD_W-1:0] ur;
        un = n[WORD_W-1] ? -n : n;
        ud = d[WORD_W-1] ? -d : d;
        uq = un / ud;
        ur = un % ud;
        q = (n[WORD_W-1] != d[WORD_W-1]) ? -uq : uq;
        r = n[WORD_W-1] ? -ur : ur;
    endfunction

    function automatic res_t compute_hilo(input cmd_t c);
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] q;
        logic [WORD_W-1:0] r;
        logic [WORD_W-1:0] p64;
        logic [2*WORD_W-1:0] wa;
        logic [2*WORD_W-1:0] wb;
        logic [2*WORD_W-1:0] p128;
        res_t o;
        a = c.operand_a;
        b = c.operand_b;
        o.read_value = '0;
        case (c.kind)
            KIND_MULT, KIND_MULTU:
            begin
                if (c.kind == KIND_MULT)
                    p64 = widen_word(a[HALF_W-1:0]) * widen_word(b[HALF_W-1:0]);
                else
                    p64 = {32'd0, a[HALF_W-1:0]} * {32'd0, b[HALF_W-1:0]};
                model_lo = widen_word(p64[HALF_W-1:0]);
                model_hi = widen_word(p64[WORD_W-1:HALF_W]);
            end
            KIND_DMULT, KIND_DMULTU:
            begin
                if (c.kind == KIND_DMULT)
                begin
                    wa = {{WORD_W{a[WORD_W-1]}}, a};
                    wb = {{WORD_W{b[WORD_W-1]}}, b};
                end
                else
                begin
                    wa = {{WORD_W{1'b0}}, a};
                    wb = {{WORD_W{1'b0}}, b};
                end
                p128 = wa * wb;
                model_hi = p128[2*WORD_W-1:WORD_W];
                model_lo = p128[WORD_W-1:0];
            end
            KIND_DIV:
            begin
                if (b[HALF_W-1:0] != '0)
                begin
                    signed_divide(widen_word(a[HALF_W-1:0]), widen_word(b[HALF_W-1:0]), q, r);
                    model_lo = widen_word(q[HALF_W-1:0]);
                    model_hi = widen_word(r[HALF_W-1:0]);
                end
                else
                begin
                    model_lo = a[HALF_W-1] ? 64'd1 : ALL_ONES;
                    model_hi = widen_word(a[HALF_W-1:0]);
                end
            end
            KIND_DIVU:
            begin
                if (b[HALF_W-1:0] != '0)
                begin
                    model_lo = widen_word(a[HALF_W-1:0] / b[HALF_W-1:0]);
                    model_hi = widen_word(a[HALF_W-1:0] % b[HALF_W-1:0]);
                end
                else
                begin
                    model_lo = ALL_ONES;
                    model_hi = widen_word(a[HALF_W-1:0]);
                end
            end
            KIND_DDIV:
            begin
                if (b != '0)
                begin
                    signed_divide(a, b, q, r);
                    model_lo = q;
                    model_hi = r;
                end
                else
                begin
                    model_lo = a[WORD_W-1] ? 64'd1 : ALL_ONES;
                    model_hi = a;
                end
            end
            KIND_DDIVU:
            begin
                if (b != '0)
                begin
                    model_lo = a / b;
                    model_hi = a % b;
                end
                else
                begin
                    model_lo = ALL_ONES;
                    model_hi = a;
                end
            end
            KIND_MFHI: o.read_value = model_hi;
            KIND_MFLO: o.read_value = model_lo;
            KIND_MTHI: model_hi = a;
            KIND_MTLO: model_lo = a;
            default: ;
        endcase
        o.hi_value = model_hi;
        o.lo_value = model_lo;
        return o;
    endfunction

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        if (mismatch_count < PRINT_CAP)
            $display("mismatch: %s got %h expected %h", what, got, want);
        mismatch_count++;
    endtask

    function automatic logic [WORD_W-1:0] random_operand();
        logic [WORD_W-1:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(9))
            5: v = {32'd0, $urandom_range(15)};
            6: v = ~{32'd0, $urandom_range(14)};
            7:
            begin
                case ($urandom_range(5))
                    0: v = '0;
                    1: v = ALL_ONES;
                    2: v = MIN64;
                    3: v = MAX64;
                    4: v = {$urandom, 32'h8000_0000};
                    default: v = {$urandom, 32'hffff_ffff};
                endcase
            end
            8: v = widen_word(v[HALF_W-1:0]);
            9: v = v >> $urandom_range(WORD_W-1);
            default: ;
        endcase
        return v;
    endfunction

    function automatic cmd_t random_cmd();
        cmd_t c;
        int pick;
        pick = $urandom_range(99);
        if (pick < 72)
            c.kind = KIND_W'($urandom_range(KIND_DDIVU, KIND_MULT));
        else if (pick < 95)
            c.kind = KIND_W'($urandom_range(KIND_MTLO, KIND_MFHI));
        else
            c.kind = KIND_W'($urandom_range(KIND_LAST, KIND_UNUSED));
        c.operand_a = random_operand();
        c.operand_b = random_operand();
        if (c.kind >= KIND_DIV && c.kind <= KIND_DDIVU && $urandom_range(9) == 0)
            c.operand_b = $urandom_range(1) ? '0 : {$urandom, 32'd0};
        return c;
    endfunction

    task automatic queue_cmd(input logic [KIND_W-1:0] k, input logic [WORD_W-1:0] a,
                             input logic [WORD_W-1:0] b);
        cmd_t c;
        c.kind = k;
        c.operand_a = a;
        c.operand_b = b;
        cmd_queue.push_back(c);
    endtask

    task automatic wait_drained();
        while (cmd_queue.size() != 0 || cmd_valid || awaited_res.size() != 0)
            @(negedge clk);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
        wait_drained();
        send_idle_pct = idle_pct;
        res_stall_pct = stall_pct;
        repeat (count) cmd_queue.push_back(random_cmd());
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            cmd <= '0;
        end
        else
        begin
            if (cmd_valid && cmd_ready)
                awaited_res.push_back(compute_hilo(cmd));
            if (!cmd_valid || cmd_ready)
            begin
                if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cmd <= cmd_queue.pop_front();
                    cmd_valid <= 1'b1;
                end
                else
                    cmd_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_ready <= 1'b0;
        else
        begin
            if (res_valid && res_ready)
            begin
                if (awaited_res.size() == 0)
                    report_mismatch("unexpected transaction hi", res.hi_value, '0);
                else
                begin
                    front_res = awaited_res.pop_front();
                    if (res.hi_value !== front_res.hi_value)
                        report_mismatch("hi_value", res.hi_value, front_res.hi_value);
                    if (res.lo_value !== front_res.lo_value)
                        report_mismatch("lo_value", res.lo_value, front_res.lo_value);
                    if (res.read_value !== front_res.read_value)
                        report_mismatch("read_value", res.read_value, front_res.read_value);
                end
            end
            res_ready <= ($urandom_range(99) >= res_stall_pct);
        end
    end

    initial
    begin
        while (!rst_n)
            @(negedge clk);

        // reads straight after reset
        queue_cmd(KIND_MFHI, ALL_ONES, ALL_ONES);
        queue_cmd(KIND_MFLO, '0, '0);
        queue_cmd(KIND_MULT, {32'h1234_5678, 32'h8000_0000}, {32'hdead_beef, 32'h8000_0000});
        queue_cmd(KIND_MULT, 64'hffff_ffff, 64'd1);
        queue_cmd(KIND_MULTU, ALL_ONES, ALL_ONES);
        queue_cmd(KIND_DMULT, MIN64, MIN64);
        queue_cmd(KIND_DMULT, ALL_ONES, MAX64);
        queue_cmd(KIND_DMULTU, ALL_ONES, ALL_ONES);
        // signed overflow wraps
        queue_cmd(KIND_DIV, {32'h5555_aaaa, 32'h8000_0000}, {32'h0f0f_0f0f, 32'hffff_ffff});
        // divide by zero, negative and non-negative dividend
        queue_cmd(KIND_DIV, 64'h8000_0001, {32'hffff_ffff, 32'd0});
        queue_cmd(KIND_DIV, {32'hffff_ffff, 32'h7fff_ffff}, '0);
        queue_cmd(KIND_DIV, 64'hffff_fff9, 64'd2);
        queue_cmd(KIND_DIVU, ALL_ONES, {32'h1, 32'd0});
        queue_cmd(KIND_DIVU, 64'hffff_ffff, 64'd3);
        queue_cmd(KIND_DDIV, MIN64, ALL_ONES);
        queue_cmd(KIND_DDIV, MIN64 | 64'd5, '0);
        queue_cmd(KIND_DDIV, MAX64, '0);
        queue_cmd(KIND_DDIV, ~64'd6, 64'd2);
        queue_cmd(KIND_DDIV, 64'd7, ~64'd1);
        queue_cmd(KIND_DDIVU, MIN64, '0);
        queue_cmd(KIND_DDIVU, ALL_ONES, 64'd1);
        queue_cmd(KIND_MTHI, ALL_ONES, '0);
        queue_cmd(KIND_MTLO, MIN64, ALL_ONES);
        queue_cmd(KIND_MFHI, '0, '0);
        queue_cmd(KIND_MFLO, '0, '0);
        queue_cmd(KIND_UNUSED, ALL_ONES, ALL_ONES);
        queue_cmd(KIND_LAST, MAX64, MIN64);

        run_phase(0, 0, 190);
        run_phase(83, 0, 185);
        run_phase(0, 83, 185);
        run_phase(16, 16, 190);
        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (awaited_res.size() != 0)
            report_mismatch("transactions never returned", WORD_W'(awaited_res.size()), '0);

        if (mismatch_count == 0)
            $display("tb_mips64_hi_lo_multiply_divide_top passed");
        else
            $display("tb_mips64_hi_lo_multiply_divide_top failed");
        $finish;
    end

    initial
    begin
        #(20 * 1_000_000);
        $display("tb_mips64_hi_lo_multiply_divide_top failed");
        $finish;
    end

endmodule
